// ----- rtl/i2cmbr_pkg.sv -----
// Shared types, register indexes and helpers for the I2C burst-read master.
package i2cmbr_pkg;

   localparam int unsigned MAX_BYTES = 16;

   // Configuration register indexes
   localparam logic CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic CSR_READ_LENGTH   = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_ADDR  = 3'd2,
      PH_AACK  = 3'd3,
      PH_READ  = 3'd4,
      PH_DACK  = 3'd5,
      PH_STOP  = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] slot_step;
      logic [3:0] bit_count;
      logic [4:0] byte_count;
      logic [7:0] shift_reg;
      logic       scl_out;
      logic       sda_out;
   } state_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_enable;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic [3:0] byte_index;
      logic       busy_res;
      logic       done_res;
      logic       nack_error;
   } result_type;

   // Zero length reads one byte; anything above MAX_BYTES saturates.
   function automatic logic [5:0] eff_length(input logic [4:0] len);
      logic [5:0] n;
      n = {1'b0, len};
      if (len == 5'd0) begin
         n = 6'd1;
      end else if (n > 6'(MAX_BYTES)) begin
         n = 6'(MAX_BYTES);
      end
      return n;
   endfunction

endpackage

// ----- rtl/i2cmbr_req_if.sv -----
// Request channel: one bus delay slot per transfer.
interface i2cmbr_req_if;
   logic valid;
   logic ready;
   logic start_request;
   logic sda_level;

   modport source (output valid, output start_request, output sda_level, input ready);
   modport sink   (input valid, input start_request, input sda_level, output ready);
endinterface

// ----- rtl/i2cmbr_rsp_if.sv -----
// Result channel: pin levels and received data for one slot per transfer.
interface i2cmbr_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_drive;
   logic       sda_enable;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic [3:0] byte_index;
   logic       busy_res;
   logic       done_res;
   logic       nack_error;

   modport source (
      output valid, output scl_level, output sda_drive, output sda_enable,
      output data_byte, output byte_valid, output byte_index, output busy_res,
      output done_res, output nack_error, input ready
   );
   modport sink (
      input valid, input scl_level, input sda_drive, input sda_enable,
      input data_byte, input byte_valid, input byte_index, input busy_res,
      input done_res, input nack_error, output ready
   );
endinterface

// ----- rtl/i2cmbr_step.sv -----
// Slot sequencer: next bus state and slot result from current state and inputs.
module i2cmbr_step (
   input  i2cmbr_pkg::state_type  cur_state,
   input  logic                   start_request,
   input  logic                   sda_level,
   input  logic [6:0]             slave_address,
   input  logic [4:0]             read_length,
   output i2cmbr_pkg::state_type  nxt_state,
   output i2cmbr_pkg::result_type result
);

   i2cmbr_pkg::phase_type ph;
   logic [1:0] stp;
   logic [3:0] bit_inc;
   logic [4:0] byte_inc;
   logic       last;
   logic       bit_done;

   // An idle slot with a start request runs as the first start slot.
   assign ph  = (cur_state.phase == i2cmbr_pkg::PH_IDLE && start_request)
                ? i2cmbr_pkg::PH_START : cur_state.phase;
   assign stp = (cur_state.phase == i2cmbr_pkg::PH_IDLE && start_request)
                ? 2'd0 : cur_state.slot_step;

   assign bit_inc  = cur_state.bit_count + 4'd1;
   assign byte_inc = cur_state.byte_count + 5'd1;
   assign bit_done = (bit_inc >= 4'd8);
   assign last     = ({1'b0, cur_state.byte_count} + 6'd1)
                     >= i2cmbr_pkg::eff_length(read_length);

   // next state
   always_comb begin
      nxt_state = cur_state;
      nxt_state.phase     = ph;
      nxt_state.slot_step = stp;
      case (ph)
         i2cmbr_pkg::PH_START: begin
            case (stp)
               2'd0: begin
                  nxt_state.scl_out = 1'b1; nxt_state.sda_out = 1'b1;
                  nxt_state.slot_step = 2'd1;
               end
               2'd1: begin
                  nxt_state.scl_out = 1'b1; nxt_state.sda_out = 1'b0;
                  nxt_state.slot_step = 2'd2;
               end
               default: begin
                  nxt_state.scl_out   = 1'b0; nxt_state.sda_out = 1'b0;
                  nxt_state.phase     = i2cmbr_pkg::PH_ADDR;
                  nxt_state.slot_step = 2'd0;
                  nxt_state.bit_count = 4'd0;
                  nxt_state.shift_reg = {slave_address, 1'b1};
               end
            endcase
         end
         i2cmbr_pkg::PH_ADDR: begin
            if (stp == 2'd0) begin
               nxt_state.scl_out   = 1'b0;
               nxt_state.sda_out   = cur_state.shift_reg[7];
               nxt_state.slot_step = 2'd1;
            end else begin
               // SDA holds the bit set up in the low slot
               nxt_state.scl_out   = 1'b1;
               nxt_state.shift_reg = {cur_state.shift_reg[6:0], 1'b0};
               nxt_state.bit_count = bit_inc;
               nxt_state.slot_step = 2'd0;
               if (bit_done) begin
                  nxt_state.phase = i2cmbr_pkg::PH_AACK;
               end
            end
         end
         i2cmbr_pkg::PH_AACK: begin
            nxt_state.sda_out = 1'b1;
            if (stp == 2'd0) begin
               nxt_state.scl_out   = 1'b0;
               nxt_state.slot_step = 2'd1;
            end else begin
               nxt_state.scl_out   = 1'b1;
               nxt_state.slot_step = 2'd0;
               if (sda_level) begin
                  nxt_state.phase = i2cmbr_pkg::PH_STOP;
               end else begin
                  nxt_state.phase      = i2cmbr_pkg::PH_READ;
                  nxt_state.bit_count  = 4'd0;
                  nxt_state.byte_count = 5'd0;
                  nxt_state.shift_reg  = 8'd0;
               end
            end
         end
         i2cmbr_pkg::PH_READ: begin
            nxt_state.sda_out = 1'b1;
            if (stp == 2'd0) begin
               nxt_state.scl_out   = 1'b0;
               nxt_state.slot_step = 2'd1;
            end else begin
               nxt_state.scl_out   = 1'b1;
               nxt_state.shift_reg = {cur_state.shift_reg[6:0], sda_level};
               nxt_state.bit_count = bit_inc;
               nxt_state.slot_step = 2'd0;
               if (bit_done) begin
                  nxt_state.phase = i2cmbr_pkg::PH_DACK;
               end
            end
         end
         i2cmbr_pkg::PH_DACK: begin
            nxt_state.sda_out = last;
            if (stp == 2'd0) begin
               nxt_state.scl_out   = 1'b0;
               nxt_state.slot_step = 2'd1;
            end else begin
               nxt_state.scl_out    = 1'b1;
               nxt_state.slot_step  = 2'd0;
               nxt_state.byte_count = byte_inc;
               if (last) begin
                  nxt_state.phase = i2cmbr_pkg::PH_STOP;
               end else begin
                  nxt_state.phase     = i2cmbr_pkg::PH_READ;
                  nxt_state.bit_count = 4'd0;
                  nxt_state.shift_reg = 8'd0;
               end
            end
         end
         i2cmbr_pkg::PH_STOP: begin
            case (stp)
               2'd0: begin
                  nxt_state.scl_out = 1'b0; nxt_state.sda_out = 1'b0;
                  nxt_state.slot_step = 2'd1;
               end
               2'd1: begin
                  nxt_state.scl_out = 1'b1; nxt_state.sda_out = 1'b0;
                  nxt_state.slot_step = 2'd2;
               end
               default: begin
                  nxt_state.scl_out   = 1'b1; nxt_state.sda_out = 1'b1;
                  nxt_state.phase     = i2cmbr_pkg::PH_IDLE;
                  nxt_state.slot_step = 2'd0;
               end
            endcase
         end
         default: begin
            // idle, or a phase code that means nothing
            nxt_state.phase     = i2cmbr_pkg::PH_IDLE;
            nxt_state.slot_step = 2'd0;
            nxt_state.scl_out   = 1'b1;
            nxt_state.sda_out   = 1'b1;
         end
      endcase
   end

   // slot result
   always_comb begin
      result            = '0;
      result.scl_level  = nxt_state.scl_out;
      result.sda_drive  = nxt_state.sda_out;
      result.busy_res   = 1'b1;
      case (ph)
         i2cmbr_pkg::PH_START,
         i2cmbr_pkg::PH_ADDR: begin
            result.sda_enable = 1'b1;
         end
         i2cmbr_pkg::PH_AACK: begin
            result.nack_error = (stp != 2'd0) && sda_level;
         end
         i2cmbr_pkg::PH_READ: begin
            if (stp != 2'd0 && bit_done) begin
               result.byte_valid = 1'b1;
               result.data_byte  = {cur_state.shift_reg[6:0], sda_level};
               result.byte_index = cur_state.byte_count[3:0];
            end
         end
         i2cmbr_pkg::PH_DACK: begin
            // master ACK drives low; the final NACK clock leaves SDA released
            result.sda_enable = !last;
         end
         i2cmbr_pkg::PH_STOP: begin
            result.sda_enable = 1'b1;
            result.done_res   = (stp != 2'd0) && (stp != 2'd1);
         end
         default: begin
            result.busy_res = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/i2c_master_burst_read.sv -----
// Top level of the bit-level I2C burst-read master.
// A slot's result is registered in the output register when its transfer is accepted.
// Throughput: one slot per cycle; a new slot is taken while the previous result waits
//   if the result side takes it in the same cycle.
// Reset (synchronous, active high): phase idle, SCL/SDA released high, counters zero,
//   slave_address 80, read_length 9, no result pending.
module i2c_master_burst_read (
   input  logic       clock,
   input  logic       reset,
   i2cmbr_req_if.sink req_bus,
   i2cmbr_rsp_if.source rsp_bus,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data
);

   // configuration registers
   logic [6:0] slave_address_ff;
   logic [4:0] read_length_ff;

   // sequencer state
   i2cmbr_pkg::state_type state_ff;
   i2cmbr_pkg::state_type state_in;

   // output register
   i2cmbr_pkg::result_type rsp_ff;
   i2cmbr_pkg::result_type rsp_in;
   logic                   rsp_valid_ff;

   logic req_accept;

   // The output register frees up whenever its result is being taken, so the
   // sequencer advances every cycle under a steady stream.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 7'd80;
         read_length_ff   <= 5'd9;
      end else if (csr_write_enable) begin
         case (csr_index)
            i2cmbr_pkg::CSR_SLAVE_ADDRESS: slave_address_ff <= csr_write_data;
            i2cmbr_pkg::CSR_READ_LENGTH:   read_length_ff   <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   i2cmbr_step u_step (
      .cur_state     (state_ff),
      .start_request (req_bus.start_request),
      .sda_level     (req_bus.sda_level),
      .slave_address (slave_address_ff),
      .read_length   (read_length_ff),
      .nxt_state     (state_in),
      .result        (rsp_in)
   );

   // State moves one slot per accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= i2cmbr_pkg::PH_IDLE;
         state_ff.slot_step  <= 2'd0;
         state_ff.bit_count  <= 4'd0;
         state_ff.byte_count <= 5'd0;
         state_ff.shift_reg  <= 8'd0;
         state_ff.scl_out    <= 1'b1;
         state_ff.sda_out    <= 1'b1;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.scl_level  = rsp_ff.scl_level;
   assign rsp_bus.sda_drive  = rsp_ff.sda_drive;
   assign rsp_bus.sda_enable = rsp_ff.sda_enable;
   assign rsp_bus.data_byte  = rsp_ff.data_byte;
   assign rsp_bus.byte_valid = rsp_ff.byte_valid;
   assign rsp_bus.byte_index = rsp_ff.byte_index;
   assign rsp_bus.busy_res   = rsp_ff.busy_res;
   assign rsp_bus.done_res   = rsp_ff.done_res;
   assign rsp_bus.nack_error = rsp_ff.nack_error;

   // every accepted slot leaves a result behind
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted slot produced no result");

   // a received byte is sampled on SCL high with SDA released
   a_byte_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_valid |-> rsp_ff.scl_level && !rsp_ff.sda_enable)
      else $error("byte reported outside a read sample slot");

   // idle phase always sits at the first slot
   a_idle_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == i2cmbr_pkg::PH_IDLE |-> state_ff.slot_step == 2'd0)
      else $error("idle with nonzero slot step");

   // byte counter never runs past the saturated length
   a_byte_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.byte_count} <= 6'(i2cmbr_pkg::MAX_BYTES))
      else $error("byte count beyond maximum");

   // an idle slot without a start request stays idle
   a_stay_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_bus.start_request && state_ff.phase == i2cmbr_pkg::PH_IDLE
      |=> state_ff.phase == i2cmbr_pkg::PH_IDLE && !rsp_ff.busy_res)
      else $error("left idle without a start request");

endmodule
